// ----- sv/nnd_pkg.sv -----
`default_nettype none
package nnd_pkg;
	localparam int MaxVectors = 64;
	localparam int MaxDims = 64;
	localparam int CoordBits = 16;
	localparam int VecBits = $clog2(MaxVectors);
	localparam int DimBits = $clog2(MaxDims);
	localparam int AddrBits = VecBits + DimBits;
	localparam int SqBits = 40;
	localparam logic [SqBits-1:0] SqMax = {SqBits{1'b1}};
	localparam int RootBits = 20;
	localparam int CfgIdxBits = 1;
	localparam int CfgDataBits = 40;
	localparam logic [CfgIdxBits-1:0] RegDimensions = 1'd0;
	localparam logic [CfgIdxBits-1:0] RegDistanceCap = 1'd1;

	// job handed from loader to compute engine
	typedef struct packed {
		logic [VecBits:0]  count;
		logic [DimBits:0]  dims;
		logic [SqBits-1:0] cap;
	} job_t;
endpackage
`default_nettype wire

// ----- sv/nearest_neighbour_distance.sv -----
`default_nettype none
// Nearest-neighbor distance engine. Coordinates (signed Q8.8) load one per
// transaction at one per cycle while in_ready is high; the transaction flagged
// last_of_set closes the set, and one result per complete vector follows in load
// order: the floor square root (Q.8) of the smallest squared distance to any
// other vector, starting from distance_cap_squared. Vector pairs run one after
// another on the single multiply-accumulate unit, self pairs are skipped, and
// each result ends with a bit-serial square root.
// Loading of the next set waits until every result of the previous set has
// been taken, since both sets would share the vector store.
module nearest_neighbour_distance (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [nnd_pkg::CfgIdxBits-1:0]  cfg_index,
	input  wire logic [nnd_pkg::CfgDataBits-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [15:0]              coordinate,
	input  wire logic                            last_of_set,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [5:0]                           vector_index,
	output logic [19:0]                          min_distance,
	output logic                                 last_result
);
	logic [6:0] dims_q;
	logic [nnd_pkg::SqBits-1:0] cap_q;
	logic [nnd_pkg::DimBits:0] dims_eff;
	logic job_valid, job_ready, wr_en;
	nnd_pkg::job_t job;
	logic [nnd_pkg::AddrBits-1:0] wr_addr;
	logic signed [nnd_pkg::CoordBits-1:0] wr_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 7'd1;
			cap_q <= nnd_pkg::SqBits'(6553600);
		end else if (cfg_we) begin
			unique case (cfg_index)
				nnd_pkg::RegDimensions: dims_q <= cfg_data[6:0];
				nnd_pkg::RegDistanceCap: cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero means one, saturate at the store width
	assign dims_eff = (dims_q == 7'd0) ? (nnd_pkg::DimBits+1)'(1)
		: (dims_q > 7'(nnd_pkg::MaxDims)) ? (nnd_pkg::DimBits+1)'(nnd_pkg::MaxDims)
		: (nnd_pkg::DimBits+1)'(dims_q);

	nnd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.coord_valid(in_valid), .coord_ready(in_ready),
		.coord(coordinate), .last(last_of_set),
		.dims_cfg(dims_eff), .cap_cfg(cap_q),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	nnd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_index(vector_index), .out_dist(min_distance), .out_last(last_result)
	);
endmodule
`default_nettype wire

// ----- sv/nnd_front.sv -----
`default_nettype none
// Loader: counts coordinates, writes the vector store, hands out a job per set that holds a complete vector.
module nnd_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            coord_valid,
	output logic                                 coord_ready,
	input  wire logic signed [nnd_pkg::CoordBits-1:0] coord,
	input  wire logic                            last,
	input  wire logic [nnd_pkg::DimBits:0]       dims_cfg,
	input  wire logic [nnd_pkg::SqBits-1:0]      cap_cfg,
	output logic                                 wr_en,
	output logic [nnd_pkg::AddrBits-1:0]         wr_addr,
	output logic signed [nnd_pkg::CoordBits-1:0] wr_data,
	output logic                                 job_valid,
	input  wire logic                            job_ready,
	output nnd_pkg::job_t                        job
);
	logic [nnd_pkg::DimBits:0]  coord_cnt_q;
	logic [nnd_pkg::VecBits:0]  vec_cnt_q;
	logic [nnd_pkg::DimBits:0]  dims_q;
	logic [nnd_pkg::DimBits:0]  cur_dims;
	logic                       job_full_q;
	logic                       first;
	logic                       vec_done;
	logic [nnd_pkg::VecBits:0]  next_vec;
	logic                       accept;

	// the store is single-set, so hold off loading while a job is pending
	// or the engine is still reading the previous set
	assign coord_ready = !job_full_q && job_ready;
	assign accept = coord_valid && coord_ready;
	assign first = (coord_cnt_q == '0) && (vec_cnt_q == '0);
	assign cur_dims = first ? dims_cfg : dims_q;
	assign vec_done = (coord_cnt_q + 1'b1) >= cur_dims;
	assign next_vec = (vec_done && vec_cnt_q < (nnd_pkg::VecBits+1)'(nnd_pkg::MaxVectors))
		? vec_cnt_q + 1'b1 : vec_cnt_q;
	assign wr_en = accept && (vec_cnt_q < (nnd_pkg::VecBits+1)'(nnd_pkg::MaxVectors))
		&& (coord_cnt_q < (nnd_pkg::DimBits+1)'(nnd_pkg::MaxDims));
	assign wr_addr = {vec_cnt_q[nnd_pkg::VecBits-1:0], coord_cnt_q[nnd_pkg::DimBits-1:0]};
	assign wr_data = coord;
	assign job_valid = job_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_cnt_q <= '0;
			vec_cnt_q <= '0;
			dims_q <= (nnd_pkg::DimBits+1)'(1);
			job_full_q <= 1'b0;
		end else begin
			if (job_full_q && job_ready) job_full_q <= 1'b0;
			if (accept) begin
				if (first) dims_q <= dims_cfg;
				if (last) begin
					coord_cnt_q <= '0;
					vec_cnt_q <= '0;
					job.count <= next_vec;
					job.dims <= cur_dims;
					job.cap <= cap_cfg;
					job_full_q <= (next_vec != '0);
				end else begin
					coord_cnt_q <= vec_done ? '0 : coord_cnt_q + 1'b1;
					vec_cnt_q <= next_vec;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/nnd_back.sv -----
`default_nettype none
// Compute engine: all-pairs distance accumulate, running minimum, bit-serial sqrt.
module nnd_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            job_valid,
	output logic                                 job_ready,
	input  wire nnd_pkg::job_t                   job,
	input  wire logic                            wr_en,
	input  wire logic [nnd_pkg::AddrBits-1:0]    wr_addr,
	input  wire logic signed [nnd_pkg::CoordBits-1:0] wr_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [nnd_pkg::VecBits-1:0]          out_index,
	output logic [nnd_pkg::RootBits-1:0]         out_dist,
	output logic                                 out_last
);
	typedef enum logic [2:0] {IDLE, READ, ACC, NEXT, ROOT, EMIT} state_t;
	state_t state_q;

	// two read ports, two copies of the store
	logic signed [nnd_pkg::CoordBits-1:0] mem_a [2**nnd_pkg::AddrBits];
	logic signed [nnd_pkg::CoordBits-1:0] mem_b [2**nnd_pkg::AddrBits];
	logic signed [nnd_pkg::CoordBits-1:0] rd_a_q, rd_b_q;
	logic [nnd_pkg::AddrBits-1:0] ra, rb;

	nnd_pkg::job_t job_q;
	logic [nnd_pkg::VecBits:0] i_q, j_q;
	logic [nnd_pkg::DimBits:0] k_q;
	logic [nnd_pkg::SqBits-1:0] sum_q, min_q;
	logic rd_live_q, sat_q;

	// square root registers
	logic [nnd_pkg::SqBits-1:0] rx_q, root_q, bit_q;
	logic [nnd_pkg::SqBits-1:0] trial;

	logic signed [nnd_pkg::CoordBits:0] diff;
	logic [nnd_pkg::CoordBits:0] adiff;
	logic [2*nnd_pkg::CoordBits+1:0] sq;
	logic [nnd_pkg::SqBits:0] sum_next;
	logic last_k;

	assign ra = {i_q[nnd_pkg::VecBits-1:0], k_q[nnd_pkg::DimBits-1:0]};
	assign rb = {j_q[nnd_pkg::VecBits-1:0], k_q[nnd_pkg::DimBits-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_a[ra];
		rd_b_q <= mem_b[rb];
	end

	// difference squared of the registered pair (17x17 bits)
	assign diff = {rd_a_q[nnd_pkg::CoordBits-1], rd_a_q} - {rd_b_q[nnd_pkg::CoordBits-1], rd_b_q};
	assign adiff = diff[nnd_pkg::CoordBits] ? (nnd_pkg::CoordBits+1)'(0) - diff : diff;
	assign sq = adiff * adiff;
	assign sum_next = {1'b0, sum_q} + (nnd_pkg::SqBits+1)'(sq);
	assign last_k = (k_q + 1'b1) >= job_q.dims;
	assign trial = root_q + bit_q;

	assign job_ready = (state_q == IDLE);
	assign out_valid = (state_q == EMIT);
	assign out_index = i_q[nnd_pkg::VecBits-1:0];
	assign out_dist = root_q[nnd_pkg::RootBits-1:0];
	assign out_last = (i_q + 1'b1) == job_q.count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			rd_live_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (job_valid) begin
						job_q <= job;
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						min_q <= job.cap;
						sum_q <= '0;
						sat_q <= 1'b0;
						rd_live_q <= 1'b0;
						state_q <= NEXT;
					end
				end
				// skip the self pair, start a fresh pair, or start the root once all pairs are done
				NEXT: begin
					if (j_q == job_q.count) begin
						rx_q <= min_q;
						root_q <= '0;
						bit_q <= nnd_pkg::SqBits'(1) << (nnd_pkg::SqBits - 2);
						state_q <= ROOT;
					end else if (j_q == i_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						k_q <= '0;
						sum_q <= '0;
						sat_q <= 1'b0;
						rd_live_q <= 1'b0;
						state_q <= READ;
					end
				end
				// issue reads, one coordinate per cycle, accumulate each in the cycle after its read
				READ: begin
					rd_live_q <= 1'b1;
					if (rd_live_q) begin
						if (sum_next[nnd_pkg::SqBits]) sat_q <= 1'b1;
						sum_q <= sum_next[nnd_pkg::SqBits-1:0];
					end
					if (last_k) state_q <= ACC;
					else k_q <= k_q + 1'b1;
				end
				ACC: begin
					if (!sat_q && !sum_next[nnd_pkg::SqBits]
						&& sum_next[nnd_pkg::SqBits-1:0] < min_q)
						min_q <= sum_next[nnd_pkg::SqBits-1:0];
					j_q <= j_q + 1'b1;
					state_q <= NEXT;
				end
				// one root bit per cycle
				ROOT: begin
					if (bit_q == '0) begin
						state_q <= EMIT;
					end else begin
						if (rx_q >= trial) begin
							rx_q <= rx_q - trial;
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				EMIT: begin
					if (out_ready) begin
						if (out_last) begin
							state_q <= IDLE;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= '0;
							min_q <= job_q.cap;
							state_q <= NEXT;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- dv/tb_nearest_neighbour_distance.sv -----
`timescale 1ns / 1ps

module tb_nearest_neighbour_distance;

	localparam logic [39:0] CapDefault = 40'd6553600;
	localparam int SettleCycles = 200;

	typedef struct {
		logic [5:0]  idx;
		logic [19:0] min_dist;
		logic        last;
	} nn_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [nnd_pkg::CfgIdxBits-1:0]  cfg_index;
	logic [nnd_pkg::CfgDataBits-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic signed [15:0]              coordinate;
	logic                            last_of_set;
	logic                            out_valid;
	logic                            out_ready;
	logic [5:0]                      vector_index;
	logic [19:0]                     min_distance;
	logic                            last_result;

	// shadow of the block: configuration and the set being loaded
	logic [6:0]         dims_cfg;
	logic [39:0]        cap_cfg;
	logic signed [15:0] vec_mem [nnd_pkg::MaxVectors][nnd_pkg::MaxDims];
	int                 coord_cnt;
	int                 vec_cnt;
	int                 set_dims;
	nn_result_t         pending_results[$];

	int errors;
	int in_idle_pct;
	int out_stall_pct;
	int hold_left;
	int coords_sent;
	int results_seen;
	int sets_sent;

	nearest_neighbour_distance u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.coordinate   (coordinate),
		.last_of_set  (last_of_set),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vector_index (vector_index),
		.min_distance (min_distance),
		.last_result  (last_result)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int clamp_dims(logic [6:0] d);
		if (d == 0) return 1;
		if (d > nnd_pkg::MaxDims) return nnd_pkg::MaxDims;
		return int'(d);
	endfunction

	// squared distance, saturating at the 40-bit ceiling
	function automatic logic [39:0] pair_dist_sq(int a, int b, int n);
		longint sum;
		longint diff;
		sum = 0;
		for (int k = 0; k < n; k++) begin
			diff = longint'(vec_mem[a][k]) - longint'(vec_mem[b][k]);
			sum += diff * diff;
			if (sum > longint'(nnd_pkg::SqMax)) return nnd_pkg::SqMax;
		end
		return sum[39:0];
	endfunction

	function automatic logic [19:0] isqrt40(logic [39:0] x);
		logic [20:0] root;
		root = 0;
		for (int b = 19; b >= 0; b--) begin
			if (({21'd0, root | (21'd1 << b)} * {21'd0, root | (21'd1 << b)}) <= {2'b0, x})
				root = root | (21'd1 << b);
		end
		return root[19:0];
	endfunction

	// track one accepted coordinate; on the closing one, queue every vector's result
	function automatic void predict_coord(logic signed [15:0] c, logic lst);
		logic [39:0] best;
		logic [39:0] d;
		nn_result_t  r;
		if (vec_cnt == 0 && coord_cnt == 0) set_dims = clamp_dims(dims_cfg);
		if (vec_cnt < nnd_pkg::MaxVectors) vec_mem[vec_cnt][coord_cnt] = c;
		coord_cnt++;
		if (coord_cnt >= set_dims) begin
			coord_cnt = 0;
			if (vec_cnt < nnd_pkg::MaxVectors) vec_cnt++;
		end
		if (!lst) return;
		for (int i = 0; i < vec_cnt; i++) begin
			best = cap_cfg;
			for (int j = 0; j < vec_cnt; j++) begin
				if (i != j) begin
					d = pair_dist_sq(i, j, set_dims);
					if (d < best) best = d;
				end
			end
			r.idx = i[5:0];
			r.min_dist = isqrt40(best);
			r.last = (i + 1 == vec_cnt);
			pending_results.push_back(r);
		end
		coord_cnt = 0;
		vec_cnt = 0;
	endfunction

	task automatic write_reg(logic [nnd_pkg::CfgIdxBits-1:0] idx,
			logic [nnd_pkg::CfgDataBits-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == nnd_pkg::RegDimensions) dims_cfg = val[6:0];
		else cap_cfg = val[39:0];
	endtask

	// one coordinate transaction; valid stays up across back-to-back sends
	task automatic send_coord(logic signed [15:0] c, logic lst);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < in_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		coordinate <= c;
		last_of_set <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_coord(c, lst);
		coords_sent++;
		if (lst) sets_sent++;
	endtask

	// drain everything, then let any silent work finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord();
		if ($urandom_range(7) == 0) return 16'($urandom);
		return $signed(16'($urandom_range(1023))) - 16'sd512;
	endfunction

	// set of nvec full vectors plus extra trailing coordinates
	task automatic send_set(int nvec, int extra);
		int n;
		int total;
		n = clamp_dims(dims_cfg);
		total = nvec * n + extra;
		for (int i = 0; i < total; i++) send_coord(rand_coord(), i == total - 1);
	endtask

	task automatic test_lone_vector();
		// reset configuration: one dimension, cap of 100.0
		send_coord(16'sh1234, 1'b1);
		send_coord(-16'sd1, 1'b1);
		wait_idle();
	endtask

	task automatic test_coord_extremes();
		write_reg(nnd_pkg::RegDimensions, 40'd1);
		write_reg(nnd_pkg::RegDistanceCap, nnd_pkg::SqMax);
		send_coord(-16'sd32768, 1'b0);
		send_coord(16'sd32767, 1'b0);
		send_coord(16'sd0, 1'b0);
		send_coord(16'sd0, 1'b1);
		wait_idle();
		write_reg(nnd_pkg::RegDistanceCap, 40'd0);
		send_coord(16'sd5, 1'b0);
		send_coord(-16'sd5, 1'b1);
		wait_idle();
	endtask

	task automatic test_partial_and_empty();
		write_reg(nnd_pkg::RegDistanceCap, CapDefault);
		write_reg(nnd_pkg::RegDimensions, 40'd3);
		// empty set: fewer coordinates than one vector
		send_coord(16'sd100, 1'b0);
		send_coord(16'sd200, 1'b1);
		wait_idle();
		// two full vectors and two dangling coordinates
		send_set(2, 2);
		wait_idle();
	endtask

	task automatic test_dims_clamp();
		write_reg(nnd_pkg::RegDimensions, 40'd0);
		send_set(3, 0);
		wait_idle();
		// saturates to the full 64 coordinates
		write_reg(nnd_pkg::RegDimensions, 40'd127);
		send_set(2, 0);
		wait_idle();
	endtask

	task automatic test_vector_overflow();
		write_reg(nnd_pkg::RegDimensions, 40'd1);
		write_reg(nnd_pkg::RegDistanceCap, 40'd1000000);
		send_set(nnd_pkg::MaxVectors + 2, 0);
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		write_reg(nnd_pkg::RegDimensions, 40'd2);
		in_idle_pct = 0;
		@(negedge clk);
		hold_left = 3000;
		@(posedge clk);
		repeat (3) send_set(8, 0);
		wait_idle();
	endtask

	task automatic test_random_sets();
		int in_pct [4] = '{0, 60, 0, 34};
		int out_pct [4] = '{0, 0, 60, 34};
		int sent_before;
		for (int p = 0; p < 4; p++) begin
			in_idle_pct = in_pct[p];
			out_stall_pct = out_pct[p];
			sent_before = coords_sent;
			while (coords_sent - sent_before < 12) begin
				case ($urandom_range(9))
					0: write_reg(nnd_pkg::RegDimensions, 40'($urandom_range(127)));
					default: write_reg(nnd_pkg::RegDimensions, 40'($urandom_range(1, 6)));
				endcase
				case ($urandom_range(5))
					0: write_reg(nnd_pkg::RegDistanceCap, 40'd0);
					1: write_reg(nnd_pkg::RegDistanceCap, nnd_pkg::SqMax);
					2: write_reg(nnd_pkg::RegDistanceCap, 40'({$urandom, $urandom}));
					default: write_reg(nnd_pkg::RegDistanceCap, 40'($urandom_range(1 << 22)));
				endcase
				if (clamp_dims(dims_cfg) > 8) send_set($urandom_range(1, 2), 0);
				else if ($urandom_range(5) == 0)
					send_set($urandom_range(0, 4), $urandom_range(1, 3));
				else send_set($urandom_range(1, 6), 0);
				wait_idle();
			end
		end
	endtask

	// result receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		nn_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result idx=%0d dist=%0d last=%0b", $time,
					vector_index, min_distance, last_result);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (vector_index !== e.idx || min_distance !== e.min_dist
						|| last_result !== e.last) begin
					$display("%0t: mismatch expected idx=%0d dist=%0d last=%0b, got idx=%0d dist=%0d last=%0b",
						$time, e.idx, e.min_dist, e.last, vector_index, min_distance,
						last_result);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		errors = 0;
		coords_sent = 0;
		results_seen = 0;
		sets_sent = 0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_left = 0;
		dims_cfg = 7'd1;
		cap_cfg = CapDefault;
		coord_cnt = 0;
		vec_cnt = 0;
		set_dims = 1;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= nnd_pkg::RegDimensions;
		cfg_data <= '0;
		in_valid <= 1'b0;
		coordinate <= '0;
		last_of_set <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_lone_vector();
		test_coord_extremes();
		test_partial_and_empty();
		test_dims_clamp();
		test_vector_overflow();
		test_output_backpressure();
		test_random_sets();

		wait_idle();
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				pending_results.size());
			errors++;
		end
		$display("Covered %0d coordinates in %0d sets, %0d results checked,",
			coords_sent, sets_sent, results_seen);
		$display("with dimension clamping, cap extremes, partial and oversize sets, stalls.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
